// ===== rtl/swmm_pkg.sv =====
package swmm_pkg;

    localparam int VAL_W = 15;
    localparam int COUNT_OUT_W = 7;

    // Full scale is 100.0 percent in UQ7.8.
    localparam int FULL_SCALE_I = 25600;
    localparam logic [VAL_W-1:0] FULL_SCALE = 15'd25600;

    // An empty cell holds a code above any saturated sample, so it sorts last.
    localparam logic [VAL_W-1:0] EMPTY_VAL = 15'h7FFF;

    // Readout groups of sixteen cells.
    localparam int GRP = 16;
    localparam int GRP_W = 4;

    // floor(n * 95 / 100) as (n * 95 * 5243) >> 19; exact for n * 95 below 2^15.
    localparam int RECIP_W = 19;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 19'd498085;
    localparam int RECIP_SH = 19;

    typedef logic [VAL_W-1:0] val_t;

    // What a cell shows its neighbours: its value and how it compares with the
    // incoming sample and with the sample that leaves the window.
    typedef struct packed {
        val_t val;
        logic lt_smp;
        logic lt_del;
    } cell_out_t;

endpackage

// ===== rtl/swmm_cell.sv =====
module swmm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  swmm_pkg::val_t      smp,
    input  swmm_pkg::val_t      del,
    input  swmm_pkg::cell_out_t left,
    input  swmm_pkg::cell_out_t right,
    output swmm_pkg::cell_out_t q
);

    swmm_pkg::val_t val_reg;
    swmm_pkg::val_t val_next;
    swmm_pkg::val_t here_val;
    swmm_pkg::val_t left_val;
    logic           here_lt;
    logic           left_lt;

    assign q.val    = val_reg;
    assign q.lt_smp = (val_reg < smp);
    assign q.lt_del = (val_reg < del);

    // Removing the leaving sample closes the gap from the right; the cells at
    // and beyond it see the value of their right neighbour.
    always_comb
    begin
        here_val = q.lt_del ? val_reg : right.val;
        here_lt  = q.lt_del ? q.lt_smp : right.lt_smp;
        left_val = left.lt_del ? left.val : val_reg;
        left_lt  = left.lt_del ? left.lt_smp : q.lt_smp;
        if (here_lt)
        begin
            val_next = here_val;
        end
        else if (left_lt)
        begin
            val_next = smp;
        end
        else
        begin
            val_next = left_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= swmm_pkg::EMPTY_VAL;
        end
        else if (upd)
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== rtl/swmm_div.sv =====
module swmm_div #(
    parameter int DW = 22,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [VW:0]   trial;
    logic          ge;

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // One quotient bit a cycle, restoring form.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? VW'(trial - {1'b0, dsr_reg}) : VW'(trial);
        end
    end

endmodule

// ===== rtl/sliding_window_min_max_mean_p95_core.sv =====
// Channel  Direction  Handshake                    Word
// sample   in         sample_valid / sample_stall  sample
// result   out        result_valid / result_stall  window_min, window_max, window_mean,
//                                                  window_p95, sample_count
//
// A new word is not taken until the last one has gone through the cell update, the
// bit-serial divider that forms the mean and the load into the output register.
// The sorted row of cells takes a new sample and drops the oldest in the same cycle.
// Reset empties the row of cells and clears the pointer, the fill count and the sum.
// A result that is stalled waits in the output register while the next word is taken.
module sliding_window_min_max_mean_p95_core #(
    parameter int WINDOW = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [14:0] sample,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [14:0] window_min,
    output logic [14:0] window_max,
    output logic [14:0] window_mean,
    output logic [14:0] window_p95,
    output logic [6:0]  sample_count
);

    localparam int AW     = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * swmm_pkg::FULL_SCALE_I + 1);
    localparam int NG     = (WINDOW + swmm_pkg::GRP - 1) / swmm_pkg::GRP;
    localparam int HIW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int NGP    = 1 << HIW;
    localparam int IDXW   = swmm_pkg::GRP_W + HIW;
    localparam int PROD_W = CNT_W + swmm_pkg::RECIP_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    localparam swmm_pkg::cell_out_t LEFT_EDGE  = '{val: '0, lt_smp: 1'b1, lt_del: 1'b1};
    localparam swmm_pkg::cell_out_t RIGHT_EDGE =
        '{val: swmm_pkg::EMPTY_VAL, lt_smp: 1'b0, lt_del: 1'b0};

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [AW-1:0]    wp_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [SUM_W-1:0] sum_reg;
    swmm_pkg::val_t   smp_reg;
    swmm_pkg::val_t   old_reg;
    logic             accept;
    logic             full;
    logic             upd;
    logic             div_start;
    logic             div_busy;
    logic [SUM_W-1:0] quotient;
    logic             load;
    swmm_pkg::val_t   del_val;
    swmm_pkg::val_t   smp_sat;

    swmm_pkg::val_t   store_mem [WINDOW];

    swmm_pkg::cell_out_t cell_q [WINDOW];

    swmm_pkg::val_t   vals_grp [NGP][swmm_pkg::GRP];
    swmm_pkg::val_t   grp_k_reg [NGP];
    swmm_pkg::val_t   grp_l_reg [NGP];
    swmm_pkg::val_t   p95_sel_reg;
    swmm_pkg::val_t   max_sel_reg;
    logic [IDXW-1:0]  k_idx_reg;
    logic [IDXW-1:0]  last_idx_reg;
    logic [PROD_W-1:0] k_prod;

    logic             result_valid_reg;
    swmm_pkg::val_t   min_out_reg;
    swmm_pkg::val_t   max_out_reg;
    swmm_pkg::val_t   mean_out_reg;
    swmm_pkg::val_t   p95_out_reg;
    logic [6:0]       count_out_reg;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign full         = (fill_reg == CNT_W'(WINDOW));
    assign upd          = (state_reg == ST_UPD);
    assign div_start    = (state_reg == ST_START);
    assign load         = (state_reg == ST_HOLD) && (!result_valid_reg || !result_stall);
    assign del_val      = full ? old_reg : swmm_pkg::EMPTY_VAL;
    assign smp_sat      = (sample > swmm_pkg::FULL_SCALE) ? swmm_pkg::FULL_SCALE : sample;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd)
            begin
                wp_reg  <= (wp_reg == AW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(smp_reg) - (full ? SUM_W'(old_reg) : '0);
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // The slot about to be overwritten holds the sample that leaves the window.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= smp_sat;
            old_reg <= store_mem[wp_reg];
        end
        if (upd)
        begin
            store_mem[wp_reg] <= smp_reg;
        end
    end

    for (genvar j = 0; j < WINDOW; j++)
    begin : g_cell
        swmm_pkg::cell_out_t left_n;
        swmm_pkg::cell_out_t right_n;
        if (j == 0)
        begin : g_first
            assign left_n = LEFT_EDGE;
        end
        else
        begin : g_inner_l
            assign left_n = cell_q[j-1];
        end
        if (j == WINDOW - 1)
        begin : g_last
            assign right_n = RIGHT_EDGE;
        end
        else
        begin : g_inner_r
            assign right_n = cell_q[j+1];
        end
        swmm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .upd   (upd),
            .smp   (smp_reg),
            .del   (del_val),
            .left  (left_n),
            .right (right_n),
            .q     (cell_q[j])
        );
    end

    for (genvar g = 0; g < NGP; g++)
    begin : g_grp
        for (genvar e = 0; e < swmm_pkg::GRP; e++)
        begin : g_ent
            if (g * swmm_pkg::GRP + e < WINDOW)
            begin : g_used
                assign vals_grp[g][e] = cell_q[g * swmm_pkg::GRP + e].val;
            end
            else
            begin : g_pad
                assign vals_grp[g][e] = swmm_pkg::EMPTY_VAL;
            end
        end
    end

    assign k_prod = PROD_W'(fill_reg) * PROD_W'(swmm_pkg::RECIP_MUL);

    // Two-level readout of the percentile and of the largest held sample; it
    // settles while the divider runs, as the cells stay put until the next word.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            k_idx_reg    <= IDXW'(k_prod >> swmm_pkg::RECIP_SH);
            last_idx_reg <= IDXW'(fill_reg - 1'b1);
        end
        for (int g = 0; g < NGP; g++)
        begin
            grp_k_reg[g] <= vals_grp[g][k_idx_reg[swmm_pkg::GRP_W-1:0]];
            grp_l_reg[g] <= vals_grp[g][last_idx_reg[swmm_pkg::GRP_W-1:0]];
        end
        p95_sel_reg <= grp_k_reg[k_idx_reg[IDXW-1:swmm_pkg::GRP_W]];
        max_sel_reg <= grp_l_reg[last_idx_reg[IDXW-1:swmm_pkg::GRP_W]];
    end

    swmm_div #(
        .DW (SUM_W),
        .VW (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            min_out_reg   <= cell_q[0].val;
            max_out_reg   <= max_sel_reg;
            mean_out_reg  <= swmm_pkg::VAL_W'(quotient);
            p95_out_reg   <= p95_sel_reg;
            count_out_reg <= swmm_pkg::COUNT_OUT_W'(fill_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign window_min   = min_out_reg;
    assign window_max   = max_out_reg;
    assign window_mean  = mean_out_reg;
    assign window_p95   = p95_out_reg;
    assign sample_count = count_out_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= AW'(WINDOW - 1))
        else $error("write pointer beyond window");

    a_p95_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (window_min <= window_p95) && (window_p95 <= window_max))
        else $error("percentile outside min and max");

    a_mean_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (window_min <= window_mean) && (window_mean <= window_max))
        else $error("mean outside min and max");
`endif

endmodule
